FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("bnvs assertion failed");

// checked on every edge, reset included
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bnvs assertion failed");

`endif

FILE: rtl/core/bnvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnvs_pkg
// shared constants, types and helpers of the neighbour vote smoother
// ----------------------------------------------------------------------------
package bnvs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 1);

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int THR_W      = 4;
    localparam int TDATA_W    = 8;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam logic [THR_W-1:0] THR_RESET = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_FLIP_THRESHOLD = 2'd2
    } t_cfg_index;

    // where the output pixel sits relative to the frame border
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge;

    typedef struct packed {
        logic frame_end;
        logic pixel;
    } t_result;

    // clamp a geometry value to 2..max and return it minus one
    function automatic logic [15:0] clamp_m1(input logic [CFG_DATA_W-1:0] v,
                                             input logic [15:0] max_v);
        logic [15:0] e;
        e = 16'(v);
        if (e < 16'd2) begin
            e = 16'd2;
        end else if (e > max_v) begin
            e = max_v;
        end
        return e - 16'd1;
    endfunction

endpackage

FILE: rtl/core/bnvs_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnvs_line_ram
// two line stores side by side, one write and one registered read port
// ----------------------------------------------------------------------------
module bnvs_line_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bnvs_pkg::COL_W-1:0] i_waddr,
    input  logic [1:0]                 i_wdata,
    input  logic [bnvs_pkg::COL_W-1:0] i_raddr,
    output logic [1:0]                 o_rdata
);
    import bnvs_pkg::*;

    // bit 0 upper line, bit 1 lower line
    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bnvs_vote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnvs_vote
// counts in-frame neighbours of each colour and decides the output pixel
// ----------------------------------------------------------------------------
module bnvs_vote (
    input  logic [2:0]                 i_left,
    input  logic [2:0]                 i_mid,
    input  logic [2:0]                 i_right,
    input  bnvs_pkg::t_edge            i_edge,
    input  logic [bnvs_pkg::THR_W-1:0] i_thr,
    output logic                       o_pixel
);
    import bnvs_pkg::*;

    function automatic logic [1:0] pop3(input logic [2:0] v);
        return 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
    endfunction

    logic [2:0]       rows;
    logic [2:0]       lmask;
    logic [2:0]       cmask;
    logic [2:0]       rmask;
    logic [THR_W-1:0] white;
    logic [THR_W-1:0] black;

    always_comb begin
        // bit 0 row above, bit 1 own row, bit 2 row below
        rows  = {~i_edge.bottom, 1'b1, ~i_edge.top};
        lmask = i_edge.left  ? 3'b000 : rows;
        rmask = i_edge.right ? 3'b000 : rows;
        cmask = rows & 3'b101;
        white = THR_W'(pop3(i_left & lmask)) + THR_W'(pop3(i_mid & cmask))
              + THR_W'(pop3(i_right & rmask));
        black = THR_W'(pop3(~i_left & lmask)) + THR_W'(pop3(~i_mid & cmask))
              + THR_W'(pop3(~i_right & rmask));
        if (i_mid[1]) begin
            o_pixel = ~(black >= i_thr);
        end else begin
            o_pixel = (white >= i_thr);
        end
    end

endmodule

FILE: rtl/core/bnvs_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnvs_out_skid
// output register plus one skid slot between the vote and the master side
// ----------------------------------------------------------------------------
module bnvs_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bnvs_pkg::t_result i_data,
    input  logic              i_m_ready,
    output logic              o_valid,
    output bnvs_pkg::t_result o_data,
    output logic              o_s_ready
);
    import bnvs_pkg::*;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out_data;
    t_result n_out_data;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid_data;
    t_result n_skid_data;
    logic    pop;

    assign pop = r_out_valid & i_m_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            // no push possible here, slave side is held off
            if (pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_push && r_out_valid && !pop) begin
            n_skid_data  = i_data;
            n_skid_valid = 1'b1;
        end else if (i_push) begin
            n_out_data  = i_data;
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_valid   = r_out_valid;
    assign o_data    = r_out_data;
    assign o_s_ready = ~r_skid_valid;

endmodule

FILE: rtl/core/binary_neighbour_vote_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_neighbour_vote_smoother_core
// 3x3 neighbour vote smoothing of a 1-bit raster image using two line stores
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[0] pixel_in, tuser command
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[0] pixel_out, tlast frame_end
//  cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
//  one item per clock sustained while m_axis_tready holds; a result enters the
//  output register, or the skid slot on a stall; the pace is set by the single
//  read port of the line ram, which is read one column ahead of the incoming pixel
//  synchronous active-low reset clears counters, window and output slots;
//  the line stores are not cleared, stale entries only reach masked taps
//  on a stall one more result parks in the skid slot, then s_axis_tready drops
// ----------------------------------------------------------------------------
module binary_neighbour_vote_smoother_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bnvs_pkg::TDATA_W-1:0]    s_axis_tdata,  // [0] pixel_in, rest zero
    input  logic                            s_axis_tuser,  // [0] command
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bnvs_pkg::TDATA_W-1:0]    m_axis_tdata,  // [0] pixel_out, rest zero
    output logic                            m_axis_tlast,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bnvs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bnvs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bnvs_pkg::*;

    // geometry kept as clamped size minus one
    logic [COL_W-1:0]  r_wm1;
    logic [COL_W-1:0]  n_wm1;
    logic [ROW_W-1:0]  r_hm1;
    logic [ROW_W-1:0]  n_hm1;
    logic [THR_W-1:0]  r_thr;
    logic [THR_W-1:0]  n_thr;

    // position state and window
    logic [8:0]        r_win;
    logic [8:0]        n_win;
    logic [IROW_W-1:0] r_in_row;
    logic [IROW_W-1:0] n_in_row;
    logic [COL_W-1:0]  r_in_col;
    logic [COL_W-1:0]  n_in_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [ROW_W-1:0]  n_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [COL_W-1:0]  n_out_col;

    logic              accept;
    logic              frame_in;
    logic              adv;
    logic              pix;
    logic              col0;
    logic              emit;
    logic [1:0]        ram_rdata;
    logic [COL_W-1:0]  ram_raddr;
    logic [2:0]        column;
    logic [2:0]        right_col;
    t_edge             pos;
    logic              vote_pixel;
    t_result           result;
    logic              skid_s_ready;
    t_result           out_data;
    logic [15:0]       w_clamp;
    logic [15:0]       h_clamp;

    assign accept   = s_axis_tvalid & s_axis_tready;
    // the whole frame is in: anything accepted now only drains
    assign frame_in = r_in_row > IROW_W'(r_hm1);
    assign adv      = accept & (frame_in | ~s_axis_tuser);
    assign pix      = frame_in ? 1'b0 : s_axis_tdata[0];
    assign col0     = (r_in_col == '0);
    assign emit     = adv & (col0 ? (r_in_row >= IROW_W'(2)) : (r_in_row >= IROW_W'(1)));

    // bit 0 two rows up, bit 1 one row up, bit 2 incoming pixel
    assign column    = {pix, ram_rdata[1], ram_rdata[0]};
    // at column zero the pending pixel is the last of its row, no right tap
    assign right_col = col0 ? 3'b000 : column;

    assign pos.top    = (r_out_row == '0);
    assign pos.bottom = (r_out_row == r_hm1);
    assign pos.left   = (r_out_col == '0);
    assign pos.right  = (r_out_col == r_wm1);

    assign w_clamp = clamp_m1(i_cfg_data, 16'(MAX_WIDTH));
    assign h_clamp = clamp_m1(i_cfg_data, 16'(MAX_HEIGHT));

    always_comb begin
        n_wm1     = r_wm1;
        n_hm1     = r_hm1;
        n_thr     = r_thr;
        n_win     = r_win;
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;

        if (adv) begin
            n_win = {column, r_win[8:3]};
            if (r_in_col == r_wm1) begin
                n_in_col = '0;
                n_in_row = r_in_row + IROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end

        if (emit) begin
            if (pos.bottom && pos.right) begin
                // frame done, next pixel opens a new frame
                n_win     = '0;
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else if (pos.right) begin
                n_out_col = '0;
                n_out_row = r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end

        // configuration must only arrive while the datapath is idle; the block does not enforce it
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: begin
                    if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                        n_wm1 = w_clamp[COL_W-1:0];
                    end else begin
                        n_hm1 = h_clamp[ROW_W-1:0];
                    end
                    n_win     = '0;
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end
                CFG_FLIP_THRESHOLD: begin
                    n_thr = i_cfg_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1     <= COL_W'(WIDTH_RESET - 1);
            r_hm1     <= ROW_W'(HEIGHT_RESET - 1);
            r_thr     <= THR_RESET;
            r_win     <= '0;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_wm1     <= n_wm1;
            r_hm1     <= n_hm1;
            r_thr     <= n_thr;
            r_win     <= n_win;
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    // read ahead at the column the next pixel will use; the write goes to the
    // current column; they differ since rows hold two or more, save at a frame reset
    assign ram_raddr = i_rst_n ? n_in_col : '0;

    bnvs_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (adv),
        .i_waddr (r_in_col),
        .i_wdata ({pix, ram_rdata[1]}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bnvs_vote u_vote (
        .i_left  (r_win[5:3]),
        .i_mid   (r_win[8:6]),
        .i_right (right_col),
        .i_edge  (pos),
        .i_thr   (r_thr),
        .o_pixel (vote_pixel)
    );

    assign result.pixel     = vote_pixel;
    assign result.frame_end = pos.bottom & pos.right;

    bnvs_out_skid u_out_skid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (emit),
        .i_data    (result),
        .i_m_ready (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_data    (out_data),
        .o_s_ready (skid_s_ready)
    );

    assign s_axis_tready = skid_s_ready;
    assign m_axis_tdata  = {{(TDATA_W-1){1'b0}}, out_data.pixel};
    assign m_axis_tlast  = out_data.frame_end;
    assign o_cfg_ready   = 1'b1;

endmodule

FILE: rtl/core/bnvs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnvs_checker
// port-level checks on the smoother core, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bnvs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bnvs_pkg::TDATA_W-1:0]    m_axis_tdata,
    input logic                            m_axis_tlast
);
    import bnvs_pkg::*;

    // a stalled result keeps its value
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // input side only backs off once a result has been left waiting
    `ASSERT_CLK_RST(a_ready_drop, i_clk, i_rst_n, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))

    // reset empties the output slots
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready)

    // padding bits of the result stay zero
    `ASSERT_CLK_RST(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:1] == '0)

endmodule

bind binary_neighbour_vote_smoother_core bnvs_checker u_bnvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
